>>> hw/rtl/cpt2d_pkg.sv
// ============================================================================
// cpt2d_pkg: shared types and constants of the 2D camera point transform
// Holds the fixed-point formats, the payload structs of both channels, the
// register indexes, the recompute sequencer states and the quarter-wave
// sine table that is built at elaboration.
// ============================================================================
package cpt2d_pkg;

    // Fixed-point formats.
    localparam int ANGLE_BITS   = 12;
    localparam int FRAC_BITS    = 16;
    localparam int COORD_W      = 32;
    localparam int TRIG_FRAC    = 16;
    localparam int TRIG_W       = TRIG_FRAC + 2;
    localparam int TRIG_MAG_W   = TRIG_FRAC + 1;
    localparam int SCALE_W      = 32;
    localparam int SCALE_SPLIT  = 16;
    localparam int ZOOM_W       = 16;
    localparam int ZOOM_FRAC    = 8;
    localparam int WIN_W        = 13;
    localparam int HALF_BITS    = WIN_W + FRAC_BITS - 1;
    localparam int QUARTER_BITS = ANGLE_BITS - 2;
    localparam int QUARTER_LEN  = 1 << QUARTER_BITS;
    localparam int MAG_CLAMP_LOG = 40;

    // Scale recompute widths.
    localparam int HZ_W       = WIN_W + ZOOM_W;
    localparam int PS_SHIFT   = 2 * FRAC_BITS - ZOOM_FRAC;
    localparam int PS_NUM_W   = HZ_W + PS_SHIFT;
    localparam int IS_NUM_W   = SCALE_W + ZOOM_FRAC;
    localparam int DIV_NUM_W  = (PS_NUM_W > IS_NUM_W) ? PS_NUM_W : IS_NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_NUM_W + 1);

    // Configuration port.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    // Register indexes.
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CAMERA_X      = 3'd0,
        REG_CAMERA_Y      = 3'd1,
        REG_ANGLE_PHASE   = 3'd2,
        REG_ZOOM_FACTOR   = 3'd3,
        REG_VIEW_HEIGHT   = 3'd4,
        REG_WINDOW_WIDTH  = 3'd5,
        REG_WINDOW_HEIGHT = 3'd6
    } t_cfg_reg;

    // Transform direction.
    localparam logic CMD_WORLD_TO_SCREEN = 1'b0;
    localparam logic CMD_SCREEN_TO_WORLD = 1'b1;

    // Recompute sequencer states.
    typedef enum logic [2:0] {
        SEQ_SIN_RD,
        SEQ_COS_RD,
        SEQ_COS_WB,
        SEQ_DIV_PS,
        SEQ_DIV_IS,
        SEQ_IDLE
    } t_seq_state;

    // Channel payloads.
    typedef struct packed {
        logic                      command;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_point_in;

    typedef struct packed {
        logic signed [COORD_W-1:0] result_x;
        logic signed [COORD_W-1:0] result_y;
        logic                      overflow;
    } t_point_out;

    // Derived camera terms handed from the control part to the datapath.
    typedef struct packed {
        logic signed [TRIG_W-1:0]  cos_value;
        logic signed [TRIG_W-1:0]  sin_value;
        logic [SCALE_W-1:0]        pixel_scale;
        logic [SCALE_W-1:0]        inverse_scale;
        logic signed [COORD_W-1:0] camera_x;
        logic signed [COORD_W-1:0] camera_y;
        logic [HALF_BITS-1:0]      half_w;
        logic [HALF_BITS-1:0]      half_h;
    } t_xform_coef;

    typedef logic [TRIG_MAG_W-1:0] t_sine_rom [QUARTER_LEN];

    // Quarter-wave sine in Q1.16 from a Q30 Taylor series in Horner form.
    function automatic t_sine_rom f_sine_rom();
        t_sine_rom   rom;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] one_q30;
        for (int i = 0; i < QUARTER_LEN; i++) begin
            one_q30 = 64'd1 << 30;
            x  = (64'd3373259426 * 64'(i) + (64'd1 << (ANGLE_BITS - 2)))
                 >> (ANGLE_BITS - 1);
            x2 = (x * x) >> 30;
            t  = one_q30;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd156;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd110;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd72;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd42;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd20;
            t  = one_q30 - ((x2 * t) >> 30) / 64'd6;
            s  = (x * t) >> 30;
            e  = (s + 64'd8192) >> 14;
            if (e > (64'd1 << TRIG_FRAC)) begin
                e = 64'd1 << TRIG_FRAC;
            end
            rom[i] = TRIG_MAG_W'(e);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = f_sine_rom();

endpackage

>>> hw/rtl/cpt2d_datapath.sv
// ============================================================================
// cpt2d_datapath: ten-stage point transform pipeline
// Pre-subtract, first rotation, scale, second rotation and final offset with
// saturation. World to screen uses the first rotation, screen to world the
// second; the unused one runs with an identity coefficient pair.
// ============================================================================
module cpt2d_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  cpt2d_pkg::t_xform_coef i_coef,
    input  logic                   i_pt_valid,
    output logic                   o_pt_ready,
    input  cpt2d_pkg::t_point_in   i_pt,
    output logic                   o_res_valid,
    input  logic                   i_res_ready,
    output cpt2d_pkg::t_point_out  o_res
);
    import cpt2d_pkg::*;

    localparam int NSTG = 10;
    localparam int U_W  = COORD_W + 1;
    localparam int P1_W = TRIG_W + U_W;
    localparam int S1_W = P1_W + 1;
    localparam int M1_W = S1_W - TRIG_FRAC;
    localparam int HI_W = M1_W + SCALE_SPLIT;
    localparam int R_W  = MAG_CLAMP_LOG + 1;
    localparam int A_W  = R_W + 1;
    localparam int P2_W = TRIG_W + A_W;
    localparam int S2_W = P2_W + 1;
    localparam int M2_W = S2_W - TRIG_FRAC;
    localparam int F_W  = M2_W + 2;
    localparam int HI_LIM = 47;

    localparam logic signed [TRIG_W-1:0] TRIG_ONE = TRIG_W'(1) << TRIG_FRAC;
    localparam logic [R_W-1:0]           MAG_CLAMP = R_W'(1) << MAG_CLAMP_LOG;

    // Rounded scale product from the two partial products, clamped.
    function automatic logic [R_W-1:0] f_scale_fin(
        input logic [HI_W-1:0] hi,
        input logic [HI_W-1:0] lo
    );
        logic [63:0] p;
        logic [63:0] r;
        p = {hi[HI_LIM-1:0], {SCALE_SPLIT{1'b0}}} + 64'(lo)
            + (64'd1 << (FRAC_BITS - 1));
        r = p >> FRAC_BITS;
        if (hi[HI_W-1:HI_LIM] != '0 || r > 64'(MAG_CLAMP)) begin
            return MAG_CLAMP;
        end
        return R_W'(r);
    endfunction

    // Handshake: each stage advances when it is empty or its successor moves.
    logic [NSTG:1] r_vld;
    logic [NSTG:1] w_adv;
    logic [NSTG:1] n_vld;

    always_comb begin
        w_adv[NSTG] = !r_vld[NSTG] || i_res_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
        n_vld = r_vld;
        for (int k = 1; k <= NSTG; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = (k == 1) ? i_pt_valid : r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_pt_ready  = w_adv[1];
    assign o_res_valid = r_vld[NSTG];

    // Stage 1: subtract the camera position or the window center.
    logic                  r1_cmd;
    logic signed [U_W-1:0] r1_u, r1_v, w1_u, w1_v;
    logic signed [U_W-1:0] w1_px, w1_py, w1_cx, w1_cy, w1_hw, w1_hh;

    always_comb begin
        w1_px = {i_pt.point_x[COORD_W-1], i_pt.point_x};
        w1_py = {i_pt.point_y[COORD_W-1], i_pt.point_y};
        w1_cx = {i_coef.camera_x[COORD_W-1], i_coef.camera_x};
        w1_cy = {i_coef.camera_y[COORD_W-1], i_coef.camera_y};
        w1_hw = U_W'(i_coef.half_w);
        w1_hh = U_W'(i_coef.half_h);
        if (i_pt.command == CMD_SCREEN_TO_WORLD) begin
            w1_u = w1_px - w1_hw;
            w1_v = w1_hh - w1_py;
        end else begin
            w1_u = w1_px - w1_cx;
            w1_v = w1_py - w1_cy;
        end
    end

    // Stage 2: first rotation products.
    logic                     r2_cmd;
    logic signed [P1_W-1:0]   r2_p0, r2_p1, r2_p2, r2_p3;
    logic signed [TRIG_W-1:0] w2_c, w2_s;

    always_comb begin
        w2_c = (r1_cmd == CMD_SCREEN_TO_WORLD) ? TRIG_ONE : i_coef.cos_value;
        w2_s = (r1_cmd == CMD_SCREEN_TO_WORLD) ? '0 : i_coef.sin_value;
    end

    // Stage 3: first rotation sums.
    logic                   r3_cmd;
    logic signed [S1_W-1:0] r3_a, r3_b;

    // Stage 4: round to coordinate format, kept as magnitude and sign.
    logic            r4_cmd, r4_sa, r4_sb;
    logic [M1_W-1:0] r4_ma, r4_mb, w4_ma, w4_mb;
    logic [S1_W-1:0] w4_abs_a, w4_abs_b;
    logic [S1_W:0]   w4_rnd_a, w4_rnd_b;

    always_comb begin
        w4_abs_a = r3_a[S1_W-1] ? S1_W'(-r3_a) : S1_W'(r3_a);
        w4_abs_b = r3_b[S1_W-1] ? S1_W'(-r3_b) : S1_W'(r3_b);
        w4_rnd_a = {1'b0, w4_abs_a} + ((S1_W+1)'(1) << (TRIG_FRAC - 1));
        w4_rnd_b = {1'b0, w4_abs_b} + ((S1_W+1)'(1) << (TRIG_FRAC - 1));
        w4_ma    = M1_W'(w4_rnd_a >> TRIG_FRAC);
        w4_mb    = M1_W'(w4_rnd_b >> TRIG_FRAC);
    end

    // Stage 5: scale partial products on the high and low halves.
    logic               r5_cmd, r5_sa, r5_sb;
    logic [HI_W-1:0]    r5_hi_a, r5_lo_a, r5_hi_b, r5_lo_b;
    logic [SCALE_W-1:0] w5_k;

    assign w5_k = (r4_cmd == CMD_SCREEN_TO_WORLD) ? i_coef.inverse_scale
                                                  : i_coef.pixel_scale;

    // Stage 6: combine, round and clamp the scaled magnitude.
    logic           r6_cmd, r6_sa, r6_sb;
    logic [R_W-1:0] r6_ra, r6_rb;

    // Stage 7: second rotation products, the sign folded into the coefficient.
    logic                     r7_cmd;
    logic signed [P2_W-1:0]   r7_p0, r7_p1, r7_p2, r7_p3;
    logic signed [TRIG_W-1:0] w7_c, w7_s, w7_ca, w7_cb, w7_sa, w7_sb;
    logic signed [A_W-1:0]    w7_ra, w7_rb;

    always_comb begin
        w7_c  = (r6_cmd == CMD_SCREEN_TO_WORLD) ? i_coef.cos_value : TRIG_ONE;
        w7_s  = (r6_cmd == CMD_SCREEN_TO_WORLD) ? -i_coef.sin_value : '0;
        w7_ca = r6_sa ? -w7_c : w7_c;
        w7_sa = r6_sa ? -w7_s : w7_s;
        w7_cb = r6_sb ? -w7_c : w7_c;
        w7_sb = r6_sb ? -w7_s : w7_s;
        w7_ra = {1'b0, r6_ra};
        w7_rb = {1'b0, r6_rb};
    end

    // Stage 8: second rotation sums.
    logic                   r8_cmd;
    logic signed [S2_W-1:0] r8_a, r8_b;

    // Stage 9: round to coordinate format; the screen y flip is a sign flip.
    logic            r9_cmd, r9_nx, r9_ny;
    logic [M2_W-1:0] r9_mx, r9_my;
    logic [S2_W-1:0] w9_abs_a, w9_abs_b;
    logic [S2_W:0]   w9_rnd_a, w9_rnd_b;

    always_comb begin
        w9_abs_a = r8_a[S2_W-1] ? S2_W'(-r8_a) : S2_W'(r8_a);
        w9_abs_b = r8_b[S2_W-1] ? S2_W'(-r8_b) : S2_W'(r8_b);
        w9_rnd_a = {1'b0, w9_abs_a} + ((S2_W+1)'(1) << (TRIG_FRAC - 1));
        w9_rnd_b = {1'b0, w9_abs_b} + ((S2_W+1)'(1) << (TRIG_FRAC - 1));
    end

    // Stage 10: add the base point and saturate to the coordinate range.
    logic signed [F_W-1:0] w10_bx, w10_by, w10_fx, w10_fy;
    logic signed [F_W-1:0] w10_max, w10_min;
    t_point_out            r_out, n_out;

    always_comb begin
        w10_max = F_W'({1'b0, {(COORD_W-1){1'b1}}});
        w10_min = -w10_max - F_W'(1);
        if (r9_cmd == CMD_SCREEN_TO_WORLD) begin
            w10_bx = F_W'(i_coef.camera_x);
            w10_by = F_W'(i_coef.camera_y);
        end else begin
            w10_bx = F_W'(i_coef.half_w);
            w10_by = F_W'(i_coef.half_h);
        end
        w10_fx = r9_nx ? w10_bx - F_W'(r9_mx) : w10_bx + F_W'(r9_mx);
        w10_fy = r9_ny ? w10_by - F_W'(r9_my) : w10_by + F_W'(r9_my);
        n_out.overflow = 1'b0;
        if (w10_fx > w10_max) begin
            n_out.result_x = {1'b0, {(COORD_W-1){1'b1}}};
            n_out.overflow = 1'b1;
        end else if (w10_fx < w10_min) begin
            n_out.result_x = {1'b1, {(COORD_W-1){1'b0}}};
            n_out.overflow = 1'b1;
        end else begin
            n_out.result_x = COORD_W'(w10_fx);
        end
        if (w10_fy > w10_max) begin
            n_out.result_y = {1'b0, {(COORD_W-1){1'b1}}};
            n_out.overflow = 1'b1;
        end else if (w10_fy < w10_min) begin
            n_out.result_y = {1'b1, {(COORD_W-1){1'b0}}};
            n_out.overflow = 1'b1;
        end else begin
            n_out.result_y = COORD_W'(w10_fy);
        end
    end

    // Stage registers, each loaded when its stage advances.
    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r1_cmd <= i_pt.command;
            r1_u   <= w1_u;
            r1_v   <= w1_v;
        end
        if (w_adv[2]) begin
            r2_cmd <= r1_cmd;
            r2_p0  <= w2_c * r1_u;
            r2_p1  <= w2_s * r1_v;
            r2_p2  <= w2_c * r1_v;
            r2_p3  <= w2_s * r1_u;
        end
        if (w_adv[3]) begin
            r3_cmd <= r2_cmd;
            r3_a   <= S1_W'(r2_p0) + S1_W'(r2_p1);
            r3_b   <= S1_W'(r2_p2) - S1_W'(r2_p3);
        end
        if (w_adv[4]) begin
            r4_cmd <= r3_cmd;
            r4_sa  <= r3_a[S1_W-1];
            r4_sb  <= r3_b[S1_W-1];
            r4_ma  <= w4_ma;
            r4_mb  <= w4_mb;
        end
        if (w_adv[5]) begin
            r5_cmd  <= r4_cmd;
            r5_sa   <= r4_sa;
            r5_sb   <= r4_sb;
            r5_hi_a <= HI_W'(r4_ma) * HI_W'(w5_k[SCALE_W-1:SCALE_SPLIT]);
            r5_lo_a <= HI_W'(r4_ma) * HI_W'(w5_k[SCALE_SPLIT-1:0]);
            r5_hi_b <= HI_W'(r4_mb) * HI_W'(w5_k[SCALE_W-1:SCALE_SPLIT]);
            r5_lo_b <= HI_W'(r4_mb) * HI_W'(w5_k[SCALE_SPLIT-1:0]);
        end
        if (w_adv[6]) begin
            r6_cmd <= r5_cmd;
            r6_sa  <= r5_sa;
            r6_sb  <= r5_sb;
            r6_ra  <= f_scale_fin(r5_hi_a, r5_lo_a);
            r6_rb  <= f_scale_fin(r5_hi_b, r5_lo_b);
        end
        if (w_adv[7]) begin
            r7_cmd <= r6_cmd;
            r7_p0  <= w7_ca * w7_ra;
            r7_p1  <= w7_sb * w7_rb;
            r7_p2  <= w7_cb * w7_rb;
            r7_p3  <= w7_sa * w7_ra;
        end
        if (w_adv[8]) begin
            r8_cmd <= r7_cmd;
            r8_a   <= S2_W'(r7_p0) + S2_W'(r7_p1);
            r8_b   <= S2_W'(r7_p2) - S2_W'(r7_p3);
        end
        if (w_adv[9]) begin
            r9_cmd <= r8_cmd;
            r9_nx  <= r8_a[S2_W-1];
            r9_ny  <= r8_b[S2_W-1] ^ (r8_cmd == CMD_WORLD_TO_SCREEN);
            r9_mx  <= M2_W'(w9_rnd_a >> TRIG_FRAC);
            r9_my  <= M2_W'(w9_rnd_b >> TRIG_FRAC);
        end
        if (w_adv[10]) begin
            r_out <= n_out;
        end
    end

    assign o_res = r_out;

    // A full pipeline facing a stalled receiver takes no new point.
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_res_ready) |-> !o_pt_ready)
        else $error("pipeline accepted a point while full and stalled");

    // A point queued behind a stalled output keeps its stage and its value.
    a_stage9_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NSTG] && r_vld[NSTG-1] && !i_res_ready)
            |=> (r_vld[NSTG-1] && $stable(r9_mx) && $stable(r9_my)))
        else $error("stage 9 lost or changed a point during a stall");

endmodule

>>> hw/rtl/camera_point_transform_2d_unit.sv
// ============================================================================
// camera_point_transform_2d_unit: 2D camera world/screen point transform
// Holds the camera registers, recomputes cosine, sine and both scale
// factors after each register write, and feeds a ten-stage datapath.
// ============================================================================
// Usage:
//   Points enter on i_pt_valid/o_pt_ready with i_pt (command, point_x,
//   point_y) and leave on o_res_valid/i_res_ready with o_res (result_x,
//   result_y, overflow). A transaction happens when valid and ready are both
//   high at a rising clock edge.
//   Result valid rises once the point has passed the ten register stages
//   of the datapath. Throughput is one point per cycle while the receiver
//   takes results and no recompute holds o_pt_ready low.
//   Registers are written through i_cfg_we/i_cfg_addr/i_cfg_wdata, one per
//   cycle; the user must write them only while no point is in flight, which
//   the block itself does not enforce. Each write to a listed register
//   starts a recompute: two sine table reads, then two bit-serial divisions
//   of DIV_NUM_W quotient bits each (53 at the default widths), during
//   which o_pt_ready stays low. Writes to other indexes are ignored.
//   Reset (synchronous, active low) loads the default camera and runs the
//   same recompute before the first point is taken.
//   When the receiver stalls, each stage holds its point; empty stages
//   still fill, so new points are taken until the pipeline is full.
// ============================================================================
module camera_point_transform_2d_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [cpt2d_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [cpt2d_pkg::CFG_DATA_W-1:0]    i_cfg_wdata,
    input  logic                                i_pt_valid,
    output logic                                o_pt_ready,
    input  cpt2d_pkg::t_point_in                i_pt,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output cpt2d_pkg::t_point_out               o_res
);
    import cpt2d_pkg::*;

    // Camera registers.
    logic signed [COORD_W-1:0] r_camera_x, r_camera_y;
    logic [ANGLE_BITS-1:0]     r_angle;
    logic [ZOOM_W-1:0]         r_zoom;
    logic [SCALE_W-1:0]        r_view_h;
    logic [WIN_W-1:0]          r_win_w, r_win_h;
    logic                      w_cfg_hit;

    // Register decode; any listed index restarts the recompute.
    always_comb begin
        unique case (i_cfg_addr)
            REG_CAMERA_X, REG_CAMERA_Y, REG_ANGLE_PHASE, REG_ZOOM_FACTOR,
            REG_VIEW_HEIGHT, REG_WINDOW_WIDTH, REG_WINDOW_HEIGHT: begin
                w_cfg_hit = i_cfg_we;
            end
            default: begin
                w_cfg_hit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_camera_x <= '0;
            r_camera_y <= '0;
            r_angle    <= '0;
            r_zoom     <= ZOOM_W'(256);
            r_view_h   <= SCALE_W'(47185920);
            r_win_w    <= WIN_W'(1280);
            r_win_h    <= WIN_W'(720);
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_CAMERA_X:      r_camera_x <= COORD_W'(i_cfg_wdata);
                REG_CAMERA_Y:      r_camera_y <= COORD_W'(i_cfg_wdata);
                REG_ANGLE_PHASE:   r_angle    <= ANGLE_BITS'(i_cfg_wdata);
                REG_ZOOM_FACTOR:   r_zoom     <= ZOOM_W'(i_cfg_wdata);
                REG_VIEW_HEIGHT:   r_view_h   <= SCALE_W'(i_cfg_wdata);
                REG_WINDOW_WIDTH:  r_win_w    <= WIN_W'(i_cfg_wdata);
                REG_WINDOW_HEIGHT: r_win_h    <= WIN_W'(i_cfg_wdata);
                default: begin
                end
            endcase
        end
    end

    // Recompute sequencer.
    t_seq_state r_state, n_state;
    logic [DIV_CNT_W-1:0] r_div_cnt;

    always_comb begin
        n_state = r_state;
        if (w_cfg_hit) begin
            n_state = SEQ_SIN_RD;
        end else begin
            unique case (r_state)
                SEQ_SIN_RD: n_state = SEQ_COS_RD;
                SEQ_COS_RD: n_state = SEQ_COS_WB;
                SEQ_COS_WB: n_state = SEQ_DIV_PS;
                SEQ_DIV_PS: begin
                    if (r_div_cnt == '0) n_state = SEQ_DIV_IS;
                end
                SEQ_DIV_IS: begin
                    if (r_div_cnt == '0) n_state = SEQ_IDLE;
                end
                SEQ_IDLE:   n_state = SEQ_IDLE;
                default:    n_state = SEQ_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_SIN_RD;
        end else begin
            r_state <= n_state;
        end
    end

    logic [ANGLE_BITS-1:0] w_phase;
    logic                  w_sin_we, w_cos_we, w_div_start, w_div_is;
    logic                  w_ps_we, w_is_we;

    always_comb begin
        w_phase     = r_angle + ANGLE_BITS'(QUARTER_LEN);
        w_sin_we    = 1'b0;
        w_cos_we    = 1'b0;
        w_div_start = 1'b0;
        w_div_is    = 1'b0;
        w_ps_we     = 1'b0;
        w_is_we     = 1'b0;
        unique case (r_state)
            SEQ_SIN_RD: w_phase = r_angle;
            SEQ_COS_RD: w_sin_we = 1'b1;
            SEQ_COS_WB: begin
                w_cos_we    = 1'b1;
                w_div_start = 1'b1;
            end
            SEQ_DIV_PS: begin
                if (r_div_cnt == '0) begin
                    w_ps_we     = 1'b1;
                    w_div_start = 1'b1;
                    w_div_is    = 1'b1;
                end
            end
            SEQ_DIV_IS: begin
                if (r_div_cnt == '0) w_is_we = 1'b1;
            end
            SEQ_IDLE: begin
            end
            default: begin
            end
        endcase
    end

    // Quarter-wave table read; odd quadrants mirror, the upper half negates.
    logic [QUARTER_BITS-1:0] w_rom_l, w_rom_addr;
    logic                    w_rom_odd;
    logic [TRIG_MAG_W-1:0]   r_rom_q;
    logic                    r_rom_one, r_rom_neg;
    logic [TRIG_W-1:0]       w_trig_mag;
    logic signed [TRIG_W-1:0] w_trig;
    logic signed [TRIG_W-1:0] r_cos, r_sin;

    always_comb begin
        w_rom_l    = w_phase[QUARTER_BITS-1:0];
        w_rom_odd  = w_phase[QUARTER_BITS];
        w_rom_addr = w_rom_odd ? QUARTER_BITS'(-w_rom_l) : w_rom_l;
        w_trig_mag = r_rom_one ? (TRIG_W'(1) << TRIG_FRAC) : TRIG_W'(r_rom_q);
        w_trig     = r_rom_neg ? -$signed(w_trig_mag) : $signed(w_trig_mag);
    end

    always_ff @(posedge i_clk) begin
        r_rom_q   <= SINE_ROM[w_rom_addr];
        r_rom_one <= w_rom_odd && (w_rom_l == '0);
        r_rom_neg <= w_phase[ANGLE_BITS-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cos <= TRIG_W'(1) << TRIG_FRAC;
            r_sin <= '0;
        end else begin
            if (w_sin_we) r_sin <= w_trig;
            if (w_cos_we) r_cos <= w_trig;
        end
    end

    // Bit-serial restoring divider shared by both scale factors.
    logic [HZ_W-1:0]      w_hz;
    logic                 w_hz_big;
    logic [DIV_NUM_W-1:0] r_div_num, w_num_ps, w_num_is;
    logic [SCALE_W-1:0]   r_div_den, r_div_rem;
    logic [DIV_NUM_W-1:0] r_div_quo;
    logic [SCALE_W:0]     w_div_t, w_div_sub;
    logic                 w_div_ge;
    logic [DIV_NUM_W:0]   w_q_rnd;
    logic [SCALE_W-1:0]   w_q_sat;
    logic [SCALE_W-1:0]   r_pixel_scale, r_inverse_scale;

    always_comb begin
        w_hz      = HZ_W'(r_win_h) * HZ_W'(r_zoom);
        w_hz_big  = ((64'(w_hz) >> (64 - PS_SHIFT)) != 64'd0);
        w_num_ps  = DIV_NUM_W'(w_hz) << PS_SHIFT;
        w_num_is  = DIV_NUM_W'(r_view_h) << ZOOM_FRAC;
        w_div_t   = {r_div_rem, r_div_num[DIV_NUM_W-1]};
        w_div_ge  = (w_div_t >= {1'b0, r_div_den});
        w_div_sub = w_div_t - {1'b0, r_div_den};
        w_q_rnd   = {1'b0, r_div_quo}
                    + (DIV_NUM_W+1)'({r_div_rem, 1'b0} >= {1'b0, r_div_den});
        w_q_sat   = (w_q_rnd > (DIV_NUM_W+1)'({SCALE_W{1'b1}}))
                    ? {SCALE_W{1'b1}} : SCALE_W'(w_q_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div_cnt <= '0;
        end else if (w_div_start) begin
            r_div_cnt <= DIV_CNT_W'(DIV_NUM_W);
        end else if (r_div_cnt != '0) begin
            r_div_cnt <= r_div_cnt - DIV_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_div_num <= w_div_is ? w_num_is : w_num_ps;
            r_div_den <= w_div_is ? SCALE_W'(w_hz) : r_view_h;
            r_div_rem <= '0;
            r_div_quo <= '0;
        end else if (r_div_cnt != '0) begin
            r_div_num <= r_div_num << 1;
            r_div_rem <= w_div_ge ? SCALE_W'(w_div_sub) : SCALE_W'(w_div_t);
            r_div_quo <= {r_div_quo[DIV_NUM_W-2:0], w_div_ge};
        end
    end

    // Scale factors, with the zero zoom, zero height and zero view cases.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pixel_scale   <= '0;
            r_inverse_scale <= '0;
        end else begin
            if (w_ps_we) begin
                if (w_hz == '0) begin
                    r_pixel_scale <= '0;
                end else if (r_view_h == '0 || w_hz_big) begin
                    r_pixel_scale <= '1;
                end else begin
                    r_pixel_scale <= w_q_sat;
                end
            end
            if (w_is_we) begin
                r_inverse_scale <= (w_hz == '0) ? '1 : w_q_sat;
            end
        end
    end

    // Datapath.
    t_xform_coef w_coef;
    logic        w_idle, w_dp_ready;

    always_comb begin
        w_coef.cos_value     = r_cos;
        w_coef.sin_value     = r_sin;
        w_coef.pixel_scale   = r_pixel_scale;
        w_coef.inverse_scale = r_inverse_scale;
        w_coef.camera_x      = r_camera_x;
        w_coef.camera_y      = r_camera_y;
        w_coef.half_w        = HALF_BITS'(r_win_w) << (FRAC_BITS - 1);
        w_coef.half_h        = HALF_BITS'(r_win_h) << (FRAC_BITS - 1);
    end

    assign w_idle     = (r_state == SEQ_IDLE);
    assign o_pt_ready = w_dp_ready && w_idle;

    cpt2d_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_coef      (w_coef),
        .i_pt_valid  (i_pt_valid && w_idle),
        .o_pt_ready  (w_dp_ready),
        .i_pt        (i_pt),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_res       (o_res)
    );

    // A write to a listed register always closes the input for the recompute.
    a_cfg_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_hit |=> !o_pt_ready)
        else $error("point accepted right after a register write");

    // Points are taken only with settled camera terms.
    a_ready_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pt_ready |-> (r_state == SEQ_IDLE && r_div_cnt == '0))
        else $error("point accepted during recompute");

    // Zero zoom or zero window height leaves the degenerate scale pair.
    a_zero_hz_scales: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == SEQ_IDLE && w_hz == '0)
            |-> (r_pixel_scale == '0 && r_inverse_scale == '1))
        else $error("scale factors wrong for zero zoom or height");

endmodule
